>>> rtl/core/ccr_pkg.sv
package ccr_pkg;

  localparam int NUM_PAGES  = 32;
  localparam int MAX_FRAMES = 32;

  localparam int PAGE_W  = 5;   // page_number width
  localparam int FRAME_W = 5;   // frame index width
  localparam int CNT_W   = 6;   // frame_count / fill count width
  localparam int FAULT_W = 16;

  localparam logic [CNT_W-1:0]   FRAME_COUNT_RST = CNT_W'(MAX_FRAMES);
  localparam logic [FAULT_W-1:0] FAULT_MAX       = {FAULT_W{1'b1}};

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [FAULT_W-1:0] fault_t;

  // commands to the clock hand unit
  typedef struct packed {
    logic clear;
    logic step;
  } hand_cmd_t;

  // one result beat
  typedef struct packed {
    logic   hit;
    frame_t frame_number;
    logic   evicted_valid;
    page_t  evicted_page;
    fault_t fault_total;
  } result_t;

endpackage

>>> rtl/core/clock_page_replacement.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------------
// in       | in_valid / in_stall   | in_page_number
// out      | out_valid / out_stall | out_hit, out_frame_number,
//          |                       | out_evicted_valid, out_evicted_page,
//          |                       | out_fault_total
// cfg      | cfg_valid / cfg_ready | cfg_frame_count
//
// A hit or a miss with free frames goes through accept, lookup and emit.
// A miss with all frames filled adds a sweep step for each frame the hand visits,
// up to the active frame count plus one; the hand steps one frame per cycle.
// Reset (or any cfg write) clears residency, use bits, hand, fill and fault count.
// The next item is accepted while a finished result still sits in the output
// register; emit holds only while that register is full and out_stall is high.
module clock_page_replacement (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_page_number,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [4:0]  out_frame_number,
  output logic        out_evicted_valid,
  output logic [4:0]  out_evicted_page,
  output logic [15:0] out_fault_total,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_frame_count
);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a page beat
  localparam logic [1:0] ST_LOOK  = 2'd1;  // residency lookup
  localparam logic [1:0] ST_SWEEP = 2'd2;  // hand sweep for a victim
  localparam logic [1:0] ST_EMIT  = 2'd3;  // hand result to output register

  logic [1:0] state_r, state_nxt;

  ccr_pkg::cnt_t   frame_count_r;
  ccr_pkg::cnt_t   n_act;
  ccr_pkg::cnt_t   filled_r, filled_nxt;
  ccr_pkg::fault_t fault_r, fault_nxt, fault_inc;
  ccr_pkg::page_t  pg_r;

  logic [ccr_pkg::NUM_PAGES-1:0]  resident_r, resident_nxt;
  logic [ccr_pkg::MAX_FRAMES-1:0] use_r;

  // written before read after every clear: no reset, no valid bits
  ccr_pkg::frame_t page_frame_r  [ccr_pkg::NUM_PAGES];
  ccr_pkg::page_t  frame_owner_r [ccr_pkg::MAX_FRAMES];

  ccr_pkg::result_t res_r, res_nxt;
  ccr_pkg::result_t out_r;
  logic             out_valid_r;

  ccr_pkg::hand_cmd_t hand_cmd;
  ccr_pkg::frame_t    hand;

  logic            cfg_we;
  logic            in_take;
  logic            out_take;
  logic            out_load;

  // per-cycle update controls
  logic            load_en;     // install pg_r at the hand
  logic            set_use_en;
  ccr_pkg::frame_t set_use_idx;
  logic            clr_use_en;  // sweep clears use bit under the hand
  logic            evict_en;
  ccr_pkg::page_t  victim;

  logic            hit_c;
  ccr_pkg::frame_t hit_frame;

  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // zero means one frame, above the array size saturates
  always_comb begin
    priority if (frame_count_r == '0) begin
      n_act = ccr_pkg::cnt_t'(1);
    end else if (frame_count_r > ccr_pkg::cnt_t'(ccr_pkg::MAX_FRAMES)) begin
      n_act = ccr_pkg::cnt_t'(ccr_pkg::MAX_FRAMES);
    end else begin
      n_act = frame_count_r;
    end
  end

  assign hit_c     = resident_r[pg_r];
  assign hit_frame = page_frame_r[pg_r];
  assign victim    = frame_owner_r[hand];
  assign fault_inc = (fault_r == ccr_pkg::FAULT_MAX) ? fault_r
                                                     : fault_r + ccr_pkg::fault_t'(1);

  ccr_hand_unit u_hand (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (hand_cmd),
    .n_act (n_act),
    .hand  (hand)
  );

  always_comb begin
    state_nxt      = state_r;
    filled_nxt     = filled_r;
    fault_nxt      = fault_r;
    res_nxt        = res_r;
    load_en        = 1'b0;
    set_use_en     = 1'b0;
    set_use_idx    = hand;
    clr_use_en     = 1'b0;
    evict_en       = 1'b0;
    hand_cmd.clear = cfg_we;
    hand_cmd.step  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (hit_c) begin
          set_use_en  = 1'b1;
          set_use_idx = hit_frame;
          res_nxt     = '{hit: 1'b1, frame_number: hit_frame, evicted_valid: 1'b0,
                          evicted_page: '0, fault_total: fault_r};
          state_nxt   = ST_EMIT;
        end else begin
          fault_nxt = fault_inc;
          if (filled_r < n_act) begin
            // free frame under the hand
            filled_nxt    = filled_r + ccr_pkg::cnt_t'(1);
            load_en       = 1'b1;
            set_use_en    = 1'b1;
            hand_cmd.step = 1'b1;
            res_nxt       = '{hit: 1'b0, frame_number: hand, evicted_valid: 1'b0,
                              evicted_page: '0, fault_total: fault_inc};
            state_nxt     = ST_EMIT;
          end else begin
            state_nxt = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        hand_cmd.step = 1'b1;
        if (use_r[hand]) begin
          // second chance: clear and move on
          clr_use_en = 1'b1;
        end else begin
          evict_en   = 1'b1;
          load_en    = 1'b1;
          set_use_en = 1'b1;
          res_nxt    = '{hit: 1'b0, frame_number: hand, evicted_valid: 1'b1,
                         evicted_page: victim, fault_total: fault_r};
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      filled_nxt = '0;
      fault_nxt  = '0;
    end
  end

  // residency update; victim differs from pg_r, which missed
  always_comb begin
    resident_nxt = resident_r;
    if (evict_en) begin
      resident_nxt[victim] = 1'b0;
    end
    if (load_en) begin
      resident_nxt[pg_r] = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      frame_count_r <= ccr_pkg::FRAME_COUNT_RST;
      filled_r      <= '0;
      fault_r       <= '0;
      resident_r    <= '0;
      use_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      filled_r <= filled_nxt;
      fault_r  <= fault_nxt;
      if (cfg_we) begin
        frame_count_r <= cfg_frame_count;
        resident_r    <= '0;
        use_r         <= '0;
      end else begin
        resident_r <= resident_nxt;
        if (clr_use_en) begin
          use_r[hand] <= 1'b0;
        end
        if (set_use_en) begin
          use_r[set_use_idx] <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and tables
  always_ff @(posedge clk) begin
    if (in_take) begin
      pg_r <= in_page_number;
    end
    if (load_en) begin
      frame_owner_r[hand] <= pg_r;
      page_frame_r[pg_r]  <= hand;
    end
    res_r <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_r.hit;
  assign out_frame_number  = out_r.frame_number;
  assign out_evicted_valid = out_r.evicted_valid;
  assign out_evicted_page  = out_r.evicted_page;
  assign out_fault_total   = out_r.fault_total;

`ifndef SYNTHESIS
  a_hand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, hand} < n_act)
    else $error("clock hand beyond active frames");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= n_act)
    else $error("fill count exceeds active frames");

  a_sweep_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SWEEP |-> filled_r == n_act)
    else $error("sweep with free frames left");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.hit && out_r.evicted_valid))
    else $error("hit result carries an eviction");

  a_fault_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(cfg_we) |-> fault_r >= $past(fault_r))
    else $error("fault count went down without a clear");
`endif

endmodule

>>> rtl/core/ccr_hand_unit.sv
module ccr_hand_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  ccr_pkg::hand_cmd_t  cmd,
  input  ccr_pkg::cnt_t       n_act,
  output ccr_pkg::frame_t     hand
);

  ccr_pkg::frame_t hand_r;
  ccr_pkg::frame_t hand_nxt;
  ccr_pkg::cnt_t   inc;

  // shared increment and wrap compare
  assign inc = {1'b0, hand_r} + ccr_pkg::cnt_t'(1);

  always_comb begin
    hand_nxt = hand_r;
    priority if (cmd.clear) begin
      hand_nxt = '0;
    end else if (cmd.step) begin
      hand_nxt = (inc >= n_act) ? '0 : inc[ccr_pkg::FRAME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hand_r <= '0;
    end else begin
      hand_r <= hand_nxt;
    end
  end

  assign hand = hand_r;

endmodule
